// ===== hw/rtl/touch_average_calibrate_macros.svh =====
// Assertion macros shared by the touch averaging and calibration RTL.
// Files that check their own logic include this header by its bare name.
`ifndef TOUCH_AVERAGE_CALIBRATE_MACROS_SVH
`define TOUCH_AVERAGE_CALIBRATE_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted
`define TAC_ASSERT_IMPLIES(label, clock, rstn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("tac: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted
`define TAC_ASSERT_NEXT(label, clock, rstn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("tac: next-cycle check failed");

`else

`define TAC_ASSERT_IMPLIES(label, clock, rstn, ante, cons)
`define TAC_ASSERT_NEXT(label, clock, rstn, ante, cons)

`endif

`endif

// ===== hw/rtl/tac_pkg.sv =====
// Package for the touch averaging and calibration block: widths, register
// indexes, reset values and the payload structs. No dependencies.
`timescale 1ns / 1ps

package tac_pkg;

    localparam int WORD_W   = 16;
    localparam int SAMPLE_W = 12;
    localparam int SUM_W    = 18;
    localparam int CNT_W    = 7;
    localparam int COEF_W   = 16;
    localparam int POS_W    = 12;
    localparam int PROD_W   = SAMPLE_W + COEF_W;
    localparam int IDX_W    = 3;

    // Largest number of words averaged per axis
    localparam logic [CNT_W-1:0] MAX_SAMPLES = 7'd64;

    localparam logic [CNT_W-1:0]  RST_SAMPLE_COUNT = 7'd20;
    localparam logic [COEF_W-1:0] RST_SCALE_X      = 16'd320;
    localparam logic [COEF_W-1:0] RST_SCALE_Y      = 16'd240;
    localparam logic [COEF_W-1:0] RST_OFFSET_X     = 16'd0;
    localparam logic [COEF_W-1:0] RST_OFFSET_Y     = 16'd0;
    localparam logic [POS_W-1:0]  RST_MAX_X        = 12'd319;
    localparam logic [POS_W-1:0]  RST_MAX_Y        = 12'd239;

    typedef enum logic [IDX_W-1:0] {
        REG_SAMPLE_COUNT = 3'd0,
        REG_SCALE_X      = 3'd1,
        REG_SCALE_Y      = 3'd2,
        REG_OFFSET_X     = 3'd3,
        REG_OFFSET_Y     = 3'd4,
        REG_MAX_X        = 3'd5,
        REG_MAX_Y        = 3'd6
    } tac_reg_idx_t;

    typedef struct packed {
        logic [WORD_W-1:0] spi_word;
        logic              pen_down;
    } tac_in_t;

    typedef struct packed {
        logic             touched;
        logic [POS_W-1:0] x_position;
        logic [POS_W-1:0] y_position;
    } tac_out_t;

    // What an accepted item causes: a result, and whether it is a touch
    typedef struct packed {
        logic emit;
        logic touched;
    } tac_event_t;

endpackage

// ===== hw/rtl/tac_accum.sv =====
// Sample decode and per-axis accumulation with the set sequencing.
// Depends on tac_pkg.
`timescale 1ns / 1ps

module tac_accum
    import tac_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             take,
    input  tac_in_t          item,
    input  logic [CNT_W-1:0] count,
    output tac_event_t       evt,
    output logic [SUM_W-1:0] sum_x,
    output logic [SUM_W-1:0] sum_y
);

    logic             phase_reg, phase_next;
    logic [CNT_W-1:0] words_reg, words_next;
    logic [SUM_W-1:0] sum_x_reg, sum_x_next;
    logic [SUM_W-1:0] sum_y_reg, sum_y_next;

    logic [SAMPLE_W-1:0] sample;
    logic [CNT_W-1:0]    words_inc;

    // 4095 minus a 12-bit value is its complement
    assign sample    = ~item.spi_word[SAMPLE_W+2:3];
    assign words_inc = words_reg + CNT_W'(1);

    always_comb
    begin
        phase_next  = phase_reg;
        words_next  = words_reg;
        sum_x_next  = sum_x_reg;
        sum_y_next  = sum_y_reg;
        evt.emit    = 1'b0;
        evt.touched = 1'b0;
        if (take)
        begin
            if (!phase_reg)
            begin
                if (words_reg == '0 && !item.pen_down)
                begin
                    // drop the word, report no touch
                    evt.emit = 1'b1;
                end
                else
                begin
                    if (words_reg == '0)
                    begin
                        sum_x_next = SUM_W'(sample);
                        sum_y_next = '0;
                    end
                    else
                    begin
                        sum_x_next = sum_x_reg + SUM_W'(sample);
                    end
                    words_next = words_inc;
                    if (words_inc >= count)
                    begin
                        phase_next = 1'b1;
                        words_next = '0;
                    end
                end
            end
            else
            begin
                sum_y_next = sum_y_reg + SUM_W'(sample);
                words_next = words_inc;
                if (words_inc >= count)
                begin
                    // last Y word closes the set; sums hold for the calibration
                    phase_next  = 1'b0;
                    words_next  = '0;
                    evt.emit    = 1'b1;
                    evt.touched = item.pen_down;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 1'b0;
            words_reg <= '0;
            sum_x_reg <= '0;
            sum_y_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            words_reg <= words_next;
            sum_x_reg <= sum_x_next;
            sum_y_reg <= sum_y_next;
        end
    end

    assign sum_x = sum_x_reg;
    assign sum_y = sum_y_reg;

endmodule

// ===== hw/rtl/tac_div.sv =====
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on tac_pkg.
`timescale 1ns / 1ps

module tac_div
    import tac_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [SUM_W-1:0] dividend,
    input  logic [CNT_W-1:0] divisor,
    output logic             done,
    output logic [SUM_W-1:0] quotient
);

    localparam int STEP_W = $clog2(SUM_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SUM_W - 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [SUM_W-1:0]  quo_reg, quo_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [CNT_W-1:0]  dvs_reg, dvs_next;

    logic [CNT_W:0] trial;
    logic           fits;

    assign trial = {rem_reg, quo_reg[SUM_W-1]};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start && !busy_reg)
        begin
            busy_next = 1'b1;
            step_next = '0;
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            // shift the next dividend bit into the remainder, subtract if it fits
            quo_next = {quo_reg[SUM_W-2:0], fits};
            rem_next = fits ? CNT_W'(trial - {1'b0, dvs_reg}) : trial[CNT_W-1:0];
            step_next = step_reg + STEP_W'(1);
            if (step_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== hw/rtl/tac_scale.sv =====
// Bit-serial shift-add scaling by a signed Q4.12 gain, then floor, offset
// and clamp in the closing SC_FIN state. Depends on tac_pkg.
`timescale 1ns / 1ps

module tac_scale
    import tac_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [SAMPLE_W-1:0] avg,
    input  logic [COEF_W-1:0]   scale,
    input  logic [COEF_W-1:0]   offset,
    input  logic [POS_W-1:0]    maxv,
    output logic                done,
    output logic [POS_W-1:0]    result
);

    localparam int BIT_W = $clog2(SAMPLE_W);
    localparam logic [BIT_W-1:0] LAST_BIT = BIT_W'(SAMPLE_W - 1);
    localparam int SUM_P_W = COEF_W + 2;

    typedef enum logic [2:0] {
        SC_IDLE = 3'b001,
        SC_RUN  = 3'b010,
        SC_FIN  = 3'b100
    } tac_sc_state_t;

    tac_sc_state_t state_reg, state_next;

    logic [BIT_W-1:0]    bit_reg, bit_next;
    logic                done_reg, done_next;
    logic [SAMPLE_W-1:0] mplier_reg, mplier_next;
    logic [COEF_W-1:0]   mcand_reg, mcand_next;
    logic [COEF_W-1:0]   offset_reg, offset_next;
    logic [POS_W-1:0]    max_reg, max_next;
    logic [PROD_W-1:0]   acc_reg, acc_next;
    logic [POS_W-1:0]    result_reg, result_next;

    logic [PROD_W-1:0]  addend;
    logic [COEF_W-1:0]  floored;
    logic [SUM_P_W-1:0] pos;

    assign addend  = mplier_reg[SAMPLE_W-1]
                   ? {{(PROD_W-COEF_W){mcand_reg[COEF_W-1]}}, mcand_reg} : '0;
    // arithmetic shift by 12 gives the floor of the product over 4096
    assign floored = acc_reg[PROD_W-1:PROD_W-COEF_W];
    assign pos     = {{2{floored[COEF_W-1]}}, floored}
                   + {{2{offset_reg[COEF_W-1]}}, offset_reg};

    always_comb
    begin
        state_next  = state_reg;
        bit_next    = bit_reg;
        done_next   = 1'b0;
        mplier_next = mplier_reg;
        mcand_next  = mcand_reg;
        offset_next = offset_reg;
        max_next    = max_reg;
        acc_next    = acc_reg;
        result_next = result_reg;
        unique case (state_reg)
            SC_IDLE:
            begin
                if (start)
                begin
                    mplier_next = avg;
                    mcand_next  = scale;
                    offset_next = offset;
                    max_next    = maxv;
                    acc_next    = '0;
                    bit_next    = '0;
                    state_next  = SC_RUN;
                end
            end
            SC_RUN:
            begin
                // multiplier bits enter MSB first
                acc_next    = {acc_reg[PROD_W-2:0], 1'b0} + addend;
                mplier_next = {mplier_reg[SAMPLE_W-2:0], 1'b0};
                bit_next    = bit_reg + BIT_W'(1);
                if (bit_reg == LAST_BIT)
                begin
                    state_next = SC_FIN;
                end
            end
            SC_FIN:
            begin
                priority if (pos[SUM_P_W-1])
                begin
                    result_next = '0;
                end
                else if (pos[SUM_P_W-2:0] > (SUM_P_W-1)'(max_reg))
                begin
                    result_next = max_reg;
                end
                else
                begin
                    result_next = pos[POS_W-1:0];
                end
                done_next  = 1'b1;
                state_next = SC_IDLE;
            end
            default:
            begin
                state_next = SC_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SC_IDLE;
            bit_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            bit_reg   <= bit_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mplier_reg <= mplier_next;
        mcand_reg  <= mcand_next;
        offset_reg <= offset_next;
        max_reg    <= max_next;
        acc_reg    <= acc_next;
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== hw/rtl/touch_average_calibrate.sv =====
// Resistive touch averaging and linear calibration, top level.
// Channels: in (spi_word, pen_down) and out (touched, x_position,
// y_position) use valid/stall; an item moves when valid is high and stall
// low. The cfg channel writes one register per valid&ready cycle; cfg_ready
// is always high. Write registers only while no set is in progress.
// Input words are taken one per cycle while in_stall is low; words inside a
// set are taken back to back. A word that opens a set with the pen up, or a
// last Y word with the pen up, yields a no-touch result through the holding
// stage and the output register. A last Y word with the pen down starts the
// calibration. Each axis runs a load step, a bit-serial divide, a hand-over
// step, a bit-serial shift-add multiply and a clamp step. The result then
// leaves through the holding stage and the output register, and no word is taken meanwhile.
// A finished result waits in a holding stage while the output is stalled;
// the input stalls whenever that stage holds an item. Reset loads the
// register defaults, clears the sums and the set position, and empties both
// result stages.
// Depends on tac_pkg, tac_accum, tac_div, tac_scale and the macro header.
`timescale 1ns / 1ps

`include "touch_average_calibrate_macros.svh"

module touch_average_calibrate
    import tac_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  tac_in_t          in_data,
    output logic             out_valid,
    input  logic             out_stall,
    output tac_out_t         out_data,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0] cfg_data
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_DIV   = 3'b010,
        ST_SCALE = 3'b100
    } tac_state_t;

    tac_state_t state_reg, state_next;

    logic [CNT_W-1:0]  sample_count_reg;
    logic [COEF_W-1:0] scale_x_reg, scale_y_reg;
    logic [COEF_W-1:0] offset_x_reg, offset_y_reg;
    logic [POS_W-1:0]  max_x_reg, max_y_reg;

    logic             axis_reg, axis_next;
    logic [POS_W-1:0] x_pos_reg, x_pos_next;
    logic             pend_valid_reg, pend_valid_next;
    tac_out_t         pend_reg, pend_next;
    logic             out_valid_reg, out_valid_next;
    tac_out_t         out_reg, out_next;

    logic [CNT_W-1:0]    count_eff;
    logic                in_take;
    tac_event_t          evt;
    logic [SUM_W-1:0]    sum_x, sum_y;
    logic                start_x, start_y, finish, zero_res, move;
    logic                div_start, div_done;
    logic [SUM_W-1:0]    div_dividend, quotient;
    logic [SAMPLE_W-1:0] avg;
    logic                scale_start, scale_done;
    logic [POS_W-1:0]    scale_result;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_count_reg <= RST_SAMPLE_COUNT;
            scale_x_reg      <= RST_SCALE_X;
            scale_y_reg      <= RST_SCALE_Y;
            offset_x_reg     <= RST_OFFSET_X;
            offset_y_reg     <= RST_OFFSET_Y;
            max_x_reg        <= RST_MAX_X;
            max_y_reg        <= RST_MAX_Y;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (tac_reg_idx_t'(cfg_index))
                REG_SAMPLE_COUNT: sample_count_reg <= cfg_data[CNT_W-1:0];
                REG_SCALE_X:      scale_x_reg      <= cfg_data;
                REG_SCALE_Y:      scale_y_reg      <= cfg_data;
                REG_OFFSET_X:     offset_x_reg     <= cfg_data;
                REG_OFFSET_Y:     offset_y_reg     <= cfg_data;
                REG_MAX_X:        max_x_reg        <= cfg_data[POS_W-1:0];
                REG_MAX_Y:        max_y_reg        <= cfg_data[POS_W-1:0];
                default:          ;
            endcase
        end
    end

    // saturate the count to 1..MAX_SAMPLES
    always_comb
    begin
        priority if (sample_count_reg == '0)
        begin
            count_eff = CNT_W'(1);
        end
        else if (sample_count_reg > MAX_SAMPLES)
        begin
            count_eff = MAX_SAMPLES;
        end
        else
        begin
            count_eff = sample_count_reg;
        end
    end

    assign in_stall = (state_reg != ST_IDLE) || pend_valid_reg;
    assign in_take  = in_valid && !in_stall;

    tac_accum u_accum (
        .clk   (clk),
        .rst_n (rst_n),
        .take  (in_take),
        .item  (in_data),
        .count (count_eff),
        .evt   (evt),
        .sum_x (sum_x),
        .sum_y (sum_y)
    );

    assign start_x  = evt.emit && evt.touched;
    assign zero_res = evt.emit && !evt.touched;
    assign start_y  = (state_reg == ST_SCALE) && scale_done && !axis_reg;
    assign finish   = (state_reg == ST_SCALE) && scale_done && axis_reg;

    assign div_start    = start_x || start_y;
    assign div_dividend = start_x ? sum_x : sum_y;

    tac_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (count_eff),
        .done     (div_done),
        .quotient (quotient)
    );

    // an average above 4095 saturates
    assign avg = (|quotient[SUM_W-1:SAMPLE_W]) ? '1 : quotient[SAMPLE_W-1:0];
    assign scale_start = (state_reg == ST_DIV) && div_done;

    tac_scale u_scale (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (scale_start),
        .avg    (avg),
        .scale  (axis_reg ? scale_y_reg : scale_x_reg),
        .offset (axis_reg ? offset_y_reg : offset_x_reg),
        .maxv   (axis_reg ? max_y_reg : max_x_reg),
        .done   (scale_done),
        .result (scale_result)
    );

    always_comb
    begin
        state_next = state_reg;
        axis_next  = axis_reg;
        x_pos_next = x_pos_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start_x)
                begin
                    axis_next  = 1'b0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE:
            begin
                if (start_y)
                begin
                    x_pos_next = scale_result;
                    axis_next  = 1'b1;
                    state_next = ST_DIV;
                end
                else if (finish)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // holding stage, then output register
    assign move = pend_valid_reg && (!out_valid_reg || !out_stall);

    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        if (move)
        begin
            out_next        = pend_reg;
            out_valid_next  = 1'b1;
            pend_valid_next = 1'b0;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (zero_res)
        begin
            pend_next       = '0;
            pend_valid_next = 1'b1;
        end
        else if (finish)
        begin
            pend_next.touched    = 1'b1;
            pend_next.x_position = x_pos_reg;
            pend_next.y_position = scale_result;
            pend_valid_next      = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            axis_reg       <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            axis_reg       <= axis_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_pos_reg <= x_pos_next;
        pend_reg  <= pend_next;
        out_reg   <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    `TAC_ASSERT_IMPLIES(a_div_done_in_div, clk, rst_n, div_done, state_reg == ST_DIV)
    `TAC_ASSERT_IMPLIES(a_scale_done_in_scale, clk, rst_n, scale_done, state_reg == ST_SCALE)
    `TAC_ASSERT_NEXT(a_pend_drains, clk, rst_n, pend_valid_reg && !out_valid_reg, !pend_valid_reg && out_valid_reg)
    `TAC_ASSERT_IMPLIES(a_no_touch_zero, clk, rst_n, pend_valid_reg && !pend_reg.touched, pend_reg.x_position == '0 && pend_reg.y_position == '0)

endmodule

// ===== verif/tb_touch_average_calibrate.sv =====
// Testbench for touch_average_calibrate: a directed table, then random touch
// sets under several register settings, checked against an in-bench predictor.
// Depends on tac_pkg and the touch_average_calibrate RTL.
`timescale 1ns / 1ps

module tb_touch_average_calibrate;
    import tac_pkg::*;

    localparam int SETTLE_CYCLES = 100;
    localparam int HOLD_CYCLES   = 400;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int PHASES        = 10;

    typedef struct packed {
        logic     typed;
        tac_out_t want;
    } typed_point_t;

    typedef struct {
        logic          is_cfg;
        tac_reg_idx_t  target;
        logic [15:0]   val;
        tac_in_t       word;
        logic          typed;
        tac_out_t      want;
    } stim_row_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    tac_in_t           in_data = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    tac_out_t          out_data;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [IDX_W-1:0]  cfg_index = '0;
    logic [WORD_W-1:0] cfg_data = '0;

    // Predictor copy of the registers
    logic [CNT_W-1:0]         set_count = RST_SAMPLE_COUNT;
    logic signed [COEF_W-1:0] gain_x  = RST_SCALE_X;
    logic signed [COEF_W-1:0] gain_y  = RST_SCALE_Y;
    logic signed [COEF_W-1:0] shift_x = RST_OFFSET_X;
    logic signed [COEF_W-1:0] shift_y = RST_OFFSET_Y;
    logic [POS_W-1:0]         top_x   = RST_MAX_X;
    logic [POS_W-1:0]         top_y   = RST_MAX_Y;

    // Predictor copy of the set state
    logic [SUM_W-1:0] acc_x = '0;
    logic [SUM_W-1:0] acc_y = '0;
    logic [CNT_W-1:0] words_in_axis = '0;
    logic             on_y_axis = 1'b0;

    tac_out_t     pending_points [$];
    typed_point_t typed_points [$];
    stim_row_t    plan [$];

    int  mismatches = 0;
    int  cycles = 0;
    bit  calm = 1'b0;
    bit  brisk = 1'b0;
    bit  hold_req = 1'b0;
    bit  hold_on = 1'b0;
    int  words_sent = 0;

    touch_average_calibrate dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    function automatic int unsigned words_per_axis();
        if (set_count == 0)
            return 1;
        if (set_count > MAX_SAMPLES)
            return MAX_SAMPLES;
        return set_count;
    endfunction

    // Average saturated at 4095, scale with floor, offset, then clamp to 0..top
    function automatic logic [POS_W-1:0] map_axis(logic [SUM_W-1:0] sum, int unsigned n,
                                                  logic signed [COEF_W-1:0] gain,
                                                  logic signed [COEF_W-1:0] shift,
                                                  logic [POS_W-1:0] top);
        longint avg;
        longint pos;
        avg = longint'(sum) / longint'(n);
        if (avg > 4095)
            avg = 4095;
        pos = ((avg * longint'(gain)) >>> 12) + longint'(shift);
        if (pos < 0)
            pos = 0;
        else if (pos > longint'(top))
            pos = longint'(top);
        return pos[POS_W-1:0];
    endfunction

    task automatic track_touch_word(input tac_in_t it, output bit emit, output tac_out_t res);
        logic [SAMPLE_W-1:0] smp;
        int unsigned n;
        smp  = 12'hFFF - it.spi_word[14:3];
        n    = words_per_axis();
        emit = 1'b0;
        res  = '0;
        if (!on_y_axis) begin
            if (words_in_axis == 0) begin
                acc_x = '0;
                acc_y = '0;
                // pen up at idle: drop the word, report no touch
                if (!it.pen_down) begin
                    emit = 1'b1;
                    return;
                end
            end
            acc_x = acc_x + SUM_W'(smp);
            words_in_axis = words_in_axis + CNT_W'(1);
            if (words_in_axis >= n) begin
                on_y_axis = 1'b1;
                words_in_axis = '0;
            end
            return;
        end
        acc_y = acc_y + SUM_W'(smp);
        words_in_axis = words_in_axis + CNT_W'(1);
        if (words_in_axis < n)
            return;
        on_y_axis = 1'b0;
        words_in_axis = '0;
        emit = 1'b1;
        if (it.pen_down) begin
            res.touched    = 1'b1;
            res.x_position = map_axis(acc_x, n, gain_x, shift_x, top_x);
            res.y_position = map_axis(acc_y, n, gain_y, shift_y, top_y);
        end
        acc_x = '0;
        acc_y = '0;
    endtask

    always @(posedge clk) begin : word_track
        bit emit;
        tac_out_t res;
        typed_point_t tp;
        if (rst_n && in_valid && !in_stall) begin
            track_touch_word(in_data, emit, res);
            tp = '0;
            if (typed_points.size() != 0)
                tp = typed_points.pop_front();
            if (emit)
                pending_points.push_back(tp.typed ? tp.want : res);
        end
    end

    always @(posedge clk) begin : result_check
        tac_out_t want;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_points.size() == 0) begin
                $error("result with nothing pending: touched=%0d x=%0d y=%0d",
                       out_data.touched, out_data.x_position, out_data.y_position);
                mismatches++;
            end else begin
                want = pending_points.pop_front();
                if (out_data.touched !== want.touched) begin
                    $error("touched: expected %0d, got %0d", want.touched, out_data.touched);
                    mismatches++;
                end
                if (out_data.x_position !== want.x_position) begin
                    $error("x_position: expected %0d, got %0d",
                           want.x_position, out_data.x_position);
                    mismatches++;
                end
                if (out_data.y_position !== want.y_position) begin
                    $error("y_position: expected %0d, got %0d",
                           want.y_position, out_data.y_position);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk) begin : watchdog
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("tb_touch_average_calibrate NOT OK");
            $finish;
        end
    end

    // Output side: random stall bursts, one long hold on request
    initial begin : receiver
        @(posedge rst_n);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                hold_on  = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_on = 1'b0;
            end else if (calm) begin
                out_stall <= 1'b0;
                @(posedge clk);
            end else if ($urandom_range(0, 2) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 19)) @(posedge clk);
            end else begin
                out_stall <= 1'b0;
                repeat ($urandom_range(1, 40)) @(posedge clk);
            end
        end
    end

    task automatic send_word(tac_in_t w, typed_point_t tp);
        int gap;
        gap = 0;
        if (!calm && !brisk && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 19);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        typed_points.push_back(tp);
        in_valid <= 1'b1;
        in_data  <= w;
        do
            @(posedge clk);
        while (!(in_valid && !in_stall));
        words_sent++;
    endtask

    task automatic send_idle_word();
        tac_in_t w;
        w.spi_word = 16'($urandom);
        w.pen_down = 1'b0;
        send_word(w, '0);
    endtask

    // One complete X+Y set; some sets toggle the pen mid-set or lift it at the end
    task automatic send_set();
        int unsigned n;
        bit broken;
        bit extreme;
        logic [15:0] ext_x;
        logic [15:0] ext_y;
        tac_in_t w;
        n       = words_per_axis();
        broken  = ($urandom_range(0, 4) == 0);
        extreme = ($urandom_range(0, 5) == 0);
        brisk   = ($urandom_range(0, 2) == 0);
        ext_x   = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        ext_y   = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        for (int k = 0; k < 2 * n; k++) begin
            if (extreme)
                w.spi_word = (k < n) ? ext_x : ext_y;
            else
                w.spi_word = 16'($urandom);
            if (k == 0)
                w.pen_down = 1'b1;
            else if (k == 2 * n - 1)
                w.pen_down = ($urandom_range(0, 4) != 0);
            else
                w.pen_down = broken ? 1'($urandom_range(0, 1)) : 1'b1;
            send_word(w, '0);
        end
        brisk = 1'b0;
    endtask

    // Drop valid, drain every expected result, then let the block go quiet
    task automatic settle();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_points.size() != 0 || typed_points.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(tac_reg_idx_t target, logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= target;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        case (target)
            REG_SAMPLE_COUNT: set_count = value[CNT_W-1:0];
            REG_SCALE_X:      gain_x    = value;
            REG_SCALE_Y:      gain_y    = value;
            REG_OFFSET_X:     shift_x   = value;
            REG_OFFSET_Y:     shift_y   = value;
            REG_MAX_X:        top_x     = value[POS_W-1:0];
            REG_MAX_Y:        top_y     = value[POS_W-1:0];
            default: ;
        endcase
    endtask

    function automatic logic [15:0] pick_gain();
        logic [15:0] g;
        if ($urandom_range(0, 1) == 0)
            return 16'($urandom);
        g = 16'($urandom_range(0, 8192));
        return ($urandom_range(0, 3) == 0) ? -g : g;
    endfunction

    function automatic logic [15:0] pick_offset();
        if ($urandom_range(0, 3) == 0)
            return 16'($urandom);
        return 16'($signed($urandom_range(0, 400)) - 200);
    endfunction

    task automatic program_phase(int p);
        logic [15:0] v [7];
        int r;
        case (p)
            0: v = '{16'(RST_SAMPLE_COUNT), RST_SCALE_X, RST_SCALE_Y, RST_OFFSET_X,
                     RST_OFFSET_Y, 16'(RST_MAX_X), 16'(RST_MAX_Y)};
            1: v = '{16'd1, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 16'h0FFF, 16'h0FFF};
            2: v = '{16'd127, 16'h1000, 16'h0800, 16'h0000, 16'hFFFF, 16'h0000, 16'h0FFF};
            default: begin
                r = $urandom_range(0, 9);
                if (r < 6)
                    v[0] = 16'($urandom_range(1, 4));
                else if (r < 9)
                    v[0] = 16'($urandom_range(5, 12));
                else
                    v[0] = 16'd0;
                v[1] = pick_gain();
                v[2] = pick_gain();
                v[3] = pick_offset();
                v[4] = pick_offset();
                v[5] = 16'($urandom_range(0, 4095));
                v[6] = 16'($urandom_range(0, 4095));
            end
        endcase
        settle();
        write_reg(REG_SAMPLE_COUNT, v[0]);
        write_reg(REG_SCALE_X, v[1]);
        write_reg(REG_SCALE_Y, v[2]);
        write_reg(REG_OFFSET_X, v[3]);
        write_reg(REG_OFFSET_Y, v[4]);
        write_reg(REG_MAX_X, v[5]);
        write_reg(REG_MAX_Y, v[6]);
        cfg_valid <= 1'b0;
    endtask

    function automatic stim_row_t set_reg(tac_reg_idx_t r, logic [15:0] v);
        stim_row_t s;
        s.is_cfg = 1'b1;
        s.target = r;
        s.val    = v;
        s.word   = '0;
        s.typed  = 1'b0;
        s.want   = '0;
        return s;
    endfunction

    function automatic stim_row_t word(logic [15:0] w, logic pen);
        stim_row_t s;
        s.is_cfg        = 1'b0;
        s.target        = REG_SAMPLE_COUNT;
        s.val           = '0;
        s.word.spi_word = w;
        s.word.pen_down = pen;
        s.typed         = 1'b0;
        s.want          = '0;
        return s;
    endfunction

    function automatic stim_row_t pinned(logic [15:0] w, logic pen, logic t,
                                         logic [11:0] x, logic [11:0] y);
        stim_row_t s;
        s = word(w, pen);
        s.typed = 1'b1;
        s.want  = '{t, x, y};
        return s;
    endfunction

    initial begin : stimulus
        bit last_cfg;
        int start;
        int budget;
        typed_point_t tp;

        plan = '{
            pinned(16'h0000, 1'b0, 1'b0, 12'd0, 12'd0),
            set_reg(REG_SAMPLE_COUNT, 16'd1),
            set_reg(REG_SCALE_X, 16'h1000),
            set_reg(REG_SCALE_Y, 16'h1000),
            set_reg(REG_MAX_X, 16'h0FFF),
            set_reg(REG_MAX_Y, 16'h0FFF),
            // unity gain: positions equal the decoded samples
            pinned(16'hFFFF, 1'b0, 1'b0, 12'd0, 12'd0),
            word(16'h0000, 1'b1), pinned(16'hFFFF, 1'b1, 1'b1, 12'd4095, 12'd0),
            word(16'hFFFF, 1'b1), pinned(16'h0000, 1'b1, 1'b1, 12'd0, 12'd4095),
            word(16'h7FF8, 1'b1), pinned(16'h8007, 1'b1, 1'b1, 12'd0, 12'd4095),
            word(16'h0000, 1'b1), pinned(16'h0000, 1'b0, 1'b0, 12'd0, 12'd0),
            word(16'h5A5A, 1'b1), word(16'hA5A5, 1'b1),
            set_reg(REG_SCALE_X, 16'h8000),
            set_reg(REG_OFFSET_X, 16'h7FFF),
            set_reg(REG_SCALE_Y, 16'h7FFF),
            set_reg(REG_OFFSET_Y, 16'h8000),
            word(16'h0000, 1'b1), word(16'h0000, 1'b1),
            word(16'hFFFF, 1'b1), pinned(16'hFFFF, 1'b1, 1'b1, 12'd4095, 12'd0),
            // pen level is ignored inside a set
            set_reg(REG_SAMPLE_COUNT, 16'd2),
            word(16'h1238, 1'b1), word(16'hEDC0, 1'b0),
            word(16'h3FF0, 1'b0), word(16'hC008, 1'b1),
            // a count of zero acts as one
            set_reg(REG_SAMPLE_COUNT, 16'd0),
            word(16'h4000, 1'b1), word(16'h0008, 1'b1)
        };

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        last_cfg = 1'b0;
        foreach (plan[i]) begin
            if (plan[i].is_cfg) begin
                if (!last_cfg)
                    settle();
                write_reg(plan[i].target, plan[i].val);
                last_cfg = 1'b1;
            end else begin
                if (last_cfg)
                    cfg_valid <= 1'b0;
                last_cfg = 1'b0;
                tp.typed = plan[i].typed;
                tp.want  = plan[i].want;
                send_word(plan[i].word, tp);
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            program_phase(p);
            if (p == PHASES - 1)
                calm = 1'b1;
            if (p == 3) begin
                // hold the output while idle words pile up behind it
                hold_req = 1'b1;
                while (!hold_on)
                    @(posedge clk);
                brisk = 1'b1;
                repeat (8) send_idle_word();
                brisk = 1'b0;
            end
            budget = (p == 0) ? 100 : (p == 2) ? 1 : 90;
            start = words_sent;
            while (words_sent - start < budget) begin
                if ($urandom_range(0, 4) == 0)
                    send_idle_word();
                else
                    send_set();
            end
        end

        settle();
        if (pending_points.size() != 0) begin
            $error("%0d expected results never arrived", pending_points.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("tb_touch_average_calibrate OK");
        else
            $display("tb_touch_average_calibrate NOT OK");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/tac_pkg.sv
hw/rtl/tac_accum.sv
hw/rtl/tac_div.sv
hw/rtl/tac_scale.sv
hw/rtl/touch_average_calibrate.sv
verif/tb_touch_average_calibrate.sv
